### rtl/dual_quadrature_distance_counter_top_macros.svh
// Assertion helpers for the dual quadrature distance counter.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef DUAL_QUADRATURE_DISTANCE_COUNTER_TOP_MACROS_SVH
`define DUAL_QUADRATURE_DISTANCE_COUNTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define DQDC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dqdc assertion failed");
`define DQDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dqdc assertion failed");
`else
`define DQDC_ASSERT_IMPL(lbl, ante, cons)
`define DQDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/dqdc_pkg.sv
`timescale 1ns / 1ps

package dqdc_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int SCALE_W        = 16;
	localparam int DIST_W         = 48;
	localparam int HALF_W         = 32;
	localparam int ACTION_W       = 2;

	// 40 mm radius, 960 counts per turn, two half counts per count, Q0.16
	localparam logic [SCALE_W-1:0] MM_PER_HALF_COUNT_RST = 16'd8578;

	localparam logic [ACTION_W-1:0] ACT_SAMPLE    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CLR_LEFT  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLR_RIGHT = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                a_left;
		logic                b_left;
		logic                a_right;
		logic                b_right;
	} dqdc_item_t;

endpackage

### rtl/dual_quadrature_distance_counter_top.sv
`timescale 1ns / 1ps
`include "dual_quadrature_distance_counter_top_macros.svh"

// Two-wheel x2 quadrature decoder. Each request either samples both encoders'
// A/B levels or clears one wheel's count; every request yields one result with
// both saturating half-count totals and both distances (count times
// cfg mm_per_half_count, signed Q.16 mm). The first sample after reset only
// captures the A levels. Throughput is one request per clock while the output
// is not stalled; a result passes the input register, the counter register,
// and the result register behind the single scale multiplier per wheel before
// it is offered. Write the scale only while no request is in flight.
module dual_quadrature_distance_counter_top import dqdc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,      // mm_per_half_count
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [7:0]     s_axis_tdata,   // a_left, b_left, a_right, b_right, zero pad
	input  logic [1:0]     s_axis_tuser,   // action
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [159:0]   m_axis_tdata    // left_distance, right_distance,
	                                       // left_half_counts, right_half_counts
);

	logic [SCALE_W-1:0]           mm_q;
	dqdc_item_t                   item_in, item_s1;
	logic                         valid_s1, valid_s2, m_valid_q;
	logic                         rdy_out, rdy2, fire, load;
	logic signed [COUNT_BITS-1:0] left_cnt_s2, right_cnt_s2;
	logic signed [DIST_W-1:0]     left_dist_q, right_dist_q;
	logic signed [HALF_W-1:0]     left_half_q, right_half_q;

	assign item_in.action  = s_axis_tuser;
	assign item_in.a_left  = s_axis_tdata[0];
	assign item_in.b_left  = s_axis_tdata[1];
	assign item_in.a_right = s_axis_tdata[2];
	assign item_in.b_right = s_axis_tdata[3];

	assign rdy_out       = !m_valid_q || m_axis_tready;
	assign rdy2          = !valid_s2 || rdy_out;
	assign load          = valid_s2 && rdy_out;
	assign fire          = valid_s1 && rdy2;
	assign s_axis_tready = !valid_s1 || rdy2;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {right_half_q, left_half_q, right_dist_q, left_dist_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q      <= MM_PER_HALF_COUNT_RST;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mm_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_out) begin
				m_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	dqdc_count #(
		.COUNT_BITS(COUNT_BITS)
	) u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (item_s1),
		.left_cnt_s2  (left_cnt_s2),
		.right_cnt_s2 (right_cnt_s2)
	);

	dqdc_scale #(
		.COUNT_BITS(COUNT_BITS)
	) u_scale (
		.clk          (clk),
		.load         (load),
		.scale        (mm_q),
		.left_cnt     (left_cnt_s2),
		.right_cnt    (right_cnt_s2),
		.left_dist_q  (left_dist_q),
		.right_dist_q (right_dist_q),
		.left_half_q  (left_half_q),
		.right_half_q (right_half_q)
	);

	`DQDC_ASSERT_IMPL(a_in_open, !valid_s1, s_axis_tready)
	`DQDC_ASSERT_NEXT(a_clr_left, fire && (item_s1.action == ACT_CLR_LEFT), left_cnt_s2 == '0)
	`DQDC_ASSERT_NEXT(a_clr_right, fire && (item_s1.action == ACT_CLR_RIGHT), right_cnt_s2 == '0)
	`DQDC_ASSERT_NEXT(a_no_drop, valid_s2 && !m_valid_q, m_axis_tvalid)

endmodule

### rtl/dqdc_count.sv
`timescale 1ns / 1ps

module dqdc_count import dqdc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  dqdc_item_t                   item,
	output logic signed [COUNT_BITS-1:0] left_cnt_s2,
	output logic signed [COUNT_BITS-1:0] right_cnt_s2
);

	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic signed [COUNT_BITS-1:0] ONE     = COUNT_BITS'(1);

	logic signed [COUNT_BITS-1:0] left_q, right_q;
	logic signed [COUNT_BITS-1:0] left_nxt, right_nxt;
	logic                         left_a_q, right_a_q, primed_q;
	logic                         left_a_nxt, right_a_nxt, primed_nxt;

	// move one half count up or down, hold at the range limits
	function automatic logic signed [COUNT_BITS-1:0] sat_step(
		input logic signed [COUNT_BITS-1:0] c,
		input logic                         up
	);
		logic signed [COUNT_BITS-1:0] r;
		if (up) begin
			r = (c == CNT_MAX) ? c : c + ONE;
		end else begin
			r = (c == CNT_MIN) ? c : c - ONE;
		end
		return r;
	endfunction

	always_comb begin
		left_nxt    = left_q;
		right_nxt   = right_q;
		left_a_nxt  = left_a_q;
		right_a_nxt = right_a_q;
		primed_nxt  = primed_q;
		unique case (item.action)
			ACT_SAMPLE: begin
				if (primed_q && (item.a_left != left_a_q)) begin
					left_nxt = sat_step(left_q, item.a_left == item.b_left);
				end
				// right wheel is mounted mirrored
				if (primed_q && (item.a_right != right_a_q)) begin
					right_nxt = sat_step(right_q, item.a_right != item.b_right);
				end
				left_a_nxt  = item.a_left;
				right_a_nxt = item.a_right;
				primed_nxt  = 1'b1;
			end
			ACT_CLR_LEFT: begin
				left_nxt = '0;
			end
			ACT_CLR_RIGHT: begin
				right_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			right_q   <= '0;
			left_a_q  <= 1'b0;
			right_a_q <= 1'b0;
			primed_q  <= 1'b0;
		end else if (fire) begin
			left_q    <= left_nxt;
			right_q   <= right_nxt;
			left_a_q  <= left_a_nxt;
			right_a_q <= right_a_nxt;
			primed_q  <= primed_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_cnt_s2  <= left_nxt;
			right_cnt_s2 <= right_nxt;
		end
	end

endmodule

### rtl/dqdc_scale.sv
`timescale 1ns / 1ps

module dqdc_scale import dqdc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         load,
	input  logic [SCALE_W-1:0]           scale,
	input  logic signed [COUNT_BITS-1:0] left_cnt,
	input  logic signed [COUNT_BITS-1:0] right_cnt,
	output logic signed [DIST_W-1:0]     left_dist_q,
	output logic signed [DIST_W-1:0]     right_dist_q,
	output logic signed [HALF_W-1:0]     left_half_q,
	output logic signed [HALF_W-1:0]     right_half_q
);

	localparam int PROD_W = COUNT_BITS + SCALE_W + 1;
	localparam int DEXT_W = (PROD_W > DIST_W) ? PROD_W : DIST_W;
	localparam int HEXT_W = (COUNT_BITS > HALF_W) ? COUNT_BITS : HALF_W;

	localparam logic signed [DEXT_W-1:0] DIST_MAX =
		{{(DEXT_W-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}};
	localparam logic signed [DEXT_W-1:0] DIST_MIN = ~DIST_MAX;
	localparam logic signed [HEXT_W-1:0] HALF_MAX =
		{{(HEXT_W-HALF_W+1){1'b0}}, {(HALF_W-1){1'b1}}};
	localparam logic signed [HEXT_W-1:0] HALF_MIN = ~HALF_MAX;

	logic signed [SCALE_W:0]   scale_s;
	logic signed [PROD_W-1:0]  left_prod, right_prod;

	function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [DEXT_W-1:0] v);
		logic signed [DEXT_W-1:0] r;
		if (v > DIST_MAX) begin
			r = DIST_MAX;
		end else if (v < DIST_MIN) begin
			r = DIST_MIN;
		end else begin
			r = v;
		end
		return r[DIST_W-1:0];
	endfunction

	function automatic logic signed [HALF_W-1:0] sat_half(input logic signed [HEXT_W-1:0] v);
		logic signed [HEXT_W-1:0] r;
		if (v > HALF_MAX) begin
			r = HALF_MAX;
		end else if (v < HALF_MIN) begin
			r = HALF_MIN;
		end else begin
			r = v;
		end
		return r[HALF_W-1:0];
	endfunction

	assign scale_s    = $signed({1'b0, scale});
	assign left_prod  = PROD_W'(left_cnt) * PROD_W'(scale_s);
	assign right_prod = PROD_W'(right_cnt) * PROD_W'(scale_s);

	always_ff @(posedge clk) begin
		if (load) begin
			left_dist_q  <= sat_dist(DEXT_W'(left_prod));
			right_dist_q <= sat_dist(DEXT_W'(right_prod));
			left_half_q  <= sat_half(HEXT_W'(left_cnt));
			right_half_q <= sat_half(HEXT_W'(right_cnt));
		end
	end

endmodule
